// ===== hw/rtl/rrts_pkg.sv =====
package rrts_pkg;

   localparam int MAX_THREADS = 16;
   localparam int SLOT_W      = $clog2(MAX_THREADS);
   localparam int CNT_W       = SLOT_W + 1;
   localparam int OP_W        = 4;
   localparam int ID_W        = 16;
   localparam int IO_W        = 32;
   localparam int WSLOT_W     = 4;
   localparam int STATUS_W    = 3;

   typedef enum logic [OP_W-1:0] {
      OP_REGISTER = 4'd0,
      OP_ENQUEUE  = 4'd1,
      OP_DISPATCH = 4'd2,
      OP_YIELD    = 4'd3,
      OP_BLOCK    = 4'd4,
      OP_EXIT     = 4'd5,
      OP_WAKE     = 4'd6,
      OP_START    = 4'd7,
      OP_SHUTDOWN = 4'd8
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_EMPTY      = 3'd1,
      ST_NOCUR      = 3'd2,
      ST_NOTFOUND   = 3'd3,
      ST_NOTBLOCKED = 3'd4,
      ST_FULL       = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      TS_RUNNABLE = 2'd0,
      TS_RUNNING  = 2'd1,
      TS_BLOCKED  = 2'd2,
      TS_DONE     = 2'd3
   } thread_state_type;

endpackage

// ===== hw/rtl/rrts_req_if.sv =====
interface rrts_req_if;
   import rrts_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           operation;
   logic [ID_W-1:0]           thread_id;
   logic signed [IO_W-1:0]    io_status;
   logic                      waiter_valid;
   logic [WSLOT_W-1:0]        waiter_slot;

   modport source (output valid, operation, thread_id, io_status, waiter_valid, waiter_slot,
                   input ready);
   modport sink   (input valid, operation, thread_id, io_status, waiter_valid, waiter_slot,
                   output ready);
endinterface

// ===== hw/rtl/rrts_rsp_if.sv =====
interface rrts_rsp_if;
   import rrts_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic [ID_W-1:0]           result_id;
   logic [WSLOT_W-1:0]        result_slot;
   logic signed [IO_W-1:0]    result_io;
   logic                      switched;

   modport source (output valid, status, result_id, result_slot, result_io, switched,
                   input ready);
   modport sink   (input valid, status, result_id, result_slot, result_io, switched,
                   output ready);
endinterface

// ===== hw/rtl/round_robin_thread_scheduler.sv =====
// Round-robin thread scheduler. Each request transaction carries one operation and yields
// exactly one response transaction. The thread table (id, state, io result) and the FIFO run
// queue sit in small memories with registered reads, stepped by one sequencer. Each request is
// decoded; enqueue and wake scan the registered slots in order from slot 0 for the id; yield,
// block and exit read and rewrite the current thread's entry, and exit with a registered join
// waiter then reads the waiter's entry and makes it runnable if it is blocked. Dispatch pops
// queue entries until it finds a runnable thread or the queue runs empty. A new request is
// taken once the sequencer is back at rest, while the previous response may still wait.
module round_robin_thread_scheduler (
   input  logic      clock,
   input  logic      reset,
   rrts_req_if.sink  req_channel,
   rrts_rsp_if.source rsp_channel
);
   import rrts_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE      = 10'b0000000001,
      S_DECODE    = 10'b0000000010,
      S_LK_CHK    = 10'b0000000100,
      S_DISP_POP  = 10'b0000001000,
      S_DISP_QCHK = 10'b0000010000,
      S_DISP_CHK  = 10'b0000100000,
      S_CUR_MOD   = 10'b0001000000,
      S_W_RD      = 10'b0010000000,
      S_W_CHK     = 10'b0100000000,
      S_RESP      = 10'b1000000000
   } seq_state_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      thread_state_type state;
      logic [IO_W-1:0]  io;
   } entry_type;

   typedef struct packed {
      status_type          status;
      logic [ID_W-1:0]     result_id;
      logic [WSLOT_W-1:0]  result_slot;
      logic [IO_W-1:0]     result_io;
      logic                switched;
   } result_type;

   seq_state_type        state_ff, state_in;
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic [SLOT_W-1:0]    head_ff, head_in;
   logic [SLOT_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     regcnt_ff, regcnt_in;
   logic [SLOT_W-1:0]    cur_slot_ff, cur_slot_in;
   logic [ID_W-1:0]      cur_id_ff, cur_id_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic                 running_ff, running_in;
   result_type           res_ff, res_in;
   result_type           out_ff, out_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [OP_W-1:0]      op_ff;
   logic [ID_W-1:0]      tid_ff;
   logic [IO_W-1:0]      io_ff;
   logic                 wvalid_ff;
   logic [WSLOT_W-1:0]   wslot_ff;

   entry_type            tab_mem [MAX_THREADS];
   entry_type            tab_rd_ff;
   logic                 mem_we;
   logic [SLOT_W-1:0]    mem_wa;
   logic [SLOT_W-1:0]    mem_ra;
   entry_type            mem_wd;

   logic [SLOT_W-1:0]    q_mem [MAX_THREADS];
   logic [SLOT_W-1:0]    q_rd_ff;
   logic                 q_we;

   logic                 push_req;
   logic [SLOT_W-1:0]    push_slot;
   logic                 req_accept;
   logic [ID_W-1:0]      from_id;
   logic [SLOT_W-1:0]    wslot_idx;

   assign req_accept        = req_channel.valid && req_channel.ready;
   assign req_channel.ready = (state_ff == S_IDLE);
   assign from_id           = cur_valid_ff ? cur_id_ff : '0;
   assign wslot_idx         = SLOT_W'(wslot_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tab_mem[mem_wa] <= mem_wd;
      end
      tab_rd_ff <= tab_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[tail_ff] <= push_slot;
      end
      q_rd_ff <= q_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff     <= req_channel.operation;
         tid_ff    <= req_channel.thread_id;
         io_ff     <= req_channel.io_status;
         wvalid_ff <= req_channel.waiter_valid;
         wslot_ff  <= req_channel.waiter_slot;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      regcnt_in    = regcnt_ff;
      cur_slot_in  = cur_slot_ff;
      cur_id_in    = cur_id_ff;
      cur_valid_in = cur_valid_ff;
      running_in   = running_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_channel.ready;
      mem_we       = 1'b0;
      mem_wa       = idx_ff;
      mem_ra       = idx_ff;
      mem_wd       = tab_rd_ff;
      push_req     = 1'b0;
      push_slot    = idx_ff;
      q_we         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_in   = '0;
            state_in = S_RESP;
            unique case (op_ff)
               OP_REGISTER: begin
                  if (regcnt_ff == CNT_W'(MAX_THREADS)) begin
                     res_in.status = ST_FULL;
                  end else if (tid_ff == '0) begin
                     res_in.status = ST_NOTFOUND;
                  end else begin
                     mem_we             = 1'b1;
                     mem_wa             = regcnt_ff[SLOT_W-1:0];
                     mem_wd             = '{id: tid_ff, state: TS_RUNNABLE, io: '0};
                     regcnt_in          = regcnt_ff + 1'b1;
                     res_in.result_id   = tid_ff;
                     res_in.result_slot = WSLOT_W'(regcnt_ff[SLOT_W-1:0]);
                  end
               end
               OP_ENQUEUE, OP_WAKE: begin
                  if (tid_ff == '0 || regcnt_ff == '0) begin
                     res_in.status = ST_NOTFOUND;
                  end else begin
                     idx_in   = '0;
                     mem_ra   = '0;
                     state_in = S_LK_CHK;
                  end
               end
               OP_DISPATCH: begin
                  if (!running_ff) begin
                     res_in.status = ST_NOCUR;
                  end else begin
                     res_in.status = ST_EMPTY;
                     state_in      = S_DISP_POP;
                  end
               end
               OP_YIELD, OP_BLOCK, OP_EXIT: begin
                  if (!cur_valid_ff || !running_ff) begin
                     res_in.status = ST_NOCUR;
                  end else begin
                     mem_ra   = cur_slot_ff;
                     state_in = S_CUR_MOD;
                  end
               end
               OP_START: begin
                  running_in = 1'b1;
               end
               OP_SHUTDOWN: begin
                  running_in   = 1'b0;
                  head_in      = '0;
                  tail_in      = '0;
                  count_in     = '0;
                  regcnt_in    = '0;
                  cur_valid_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         S_LK_CHK: begin
            if (tab_rd_ff.id == tid_ff) begin
               state_in = S_RESP;
               if (op_ff == OP_ENQUEUE) begin
                  push_req = 1'b1;
               end else if (tab_rd_ff.state != TS_BLOCKED) begin
                  res_in.status = ST_NOTBLOCKED;
               end else begin
                  mem_we   = 1'b1;
                  mem_wd   = '{id: tab_rd_ff.id, state: TS_RUNNABLE, io: io_ff};
                  push_req = 1'b1;
               end
            end else if (({1'b0, idx_ff} + 1'b1) >= regcnt_ff) begin
               res_in.status = ST_NOTFOUND;
               state_in      = S_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
               mem_ra = idx_ff + 1'b1;
            end
         end
         S_DISP_POP: begin
            if (count_ff == '0) begin
               state_in = S_RESP;
            end else begin
               head_in  = (head_ff == SLOT_W'(MAX_THREADS - 1)) ? '0 : head_ff + 1'b1;
               count_in = count_ff - 1'b1;
               state_in = S_DISP_QCHK;
            end
         end
         S_DISP_QCHK: begin
            idx_in   = q_rd_ff;
            mem_ra   = q_rd_ff;
            state_in = S_DISP_CHK;
         end
         S_DISP_CHK: begin
            if (tab_rd_ff.state == TS_RUNNABLE) begin
               mem_we             = 1'b1;
               mem_wd             = '{id: tab_rd_ff.id, state: TS_RUNNING, io: tab_rd_ff.io};
               cur_slot_in        = idx_ff;
               cur_id_in          = tab_rd_ff.id;
               cur_valid_in       = 1'b1;
               res_in.status      = ST_OK;
               res_in.result_id   = tab_rd_ff.id;
               res_in.result_slot = WSLOT_W'(idx_ff);
               res_in.result_io   = tab_rd_ff.io;
               res_in.switched    = (from_id != tab_rd_ff.id);
               state_in           = S_RESP;
            end else begin
               state_in = S_DISP_POP;
            end
         end
         S_CUR_MOD: begin
            mem_we   = 1'b1;
            mem_wa   = cur_slot_ff;
            state_in = S_RESP;
            if (op_ff == OP_YIELD) begin
               mem_wd    = '{id: tab_rd_ff.id, state: TS_RUNNABLE, io: tab_rd_ff.io};
               push_req  = 1'b1;
               push_slot = cur_slot_ff;
            end else if (op_ff == OP_BLOCK) begin
               mem_wd = '{id: tab_rd_ff.id, state: TS_BLOCKED, io: tab_rd_ff.io};
            end else begin
               mem_wd = '{id: tab_rd_ff.id, state: TS_DONE, io: tab_rd_ff.io};
               if (wvalid_ff && (CNT_W'(wslot_ff) < regcnt_ff)) begin
                  state_in = S_W_RD;
               end
            end
         end
         S_W_RD: begin
            mem_ra   = wslot_idx;
            state_in = S_W_CHK;
         end
         S_W_CHK: begin
            state_in = S_RESP;
            if (tab_rd_ff.state == TS_BLOCKED) begin
               mem_we    = 1'b1;
               mem_wa    = wslot_idx;
               mem_wd    = '{id: tab_rd_ff.id, state: TS_RUNNABLE, io: tab_rd_ff.io};
               push_req  = 1'b1;
               push_slot = wslot_idx;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_channel.ready) begin
               out_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (push_req) begin
         if (count_ff == CNT_W'(MAX_THREADS)) begin
            res_in.status = ST_FULL;
         end else begin
            q_we     = 1'b1;
            tail_in  = (tail_ff == SLOT_W'(MAX_THREADS - 1)) ? '0 : tail_ff + 1'b1;
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         regcnt_ff    <= '0;
         cur_slot_ff  <= '0;
         cur_valid_ff <= 1'b0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         regcnt_ff    <= regcnt_in;
         cur_slot_ff  <= cur_slot_in;
         cur_valid_ff <= cur_valid_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      cur_id_ff <= cur_id_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
   end

   assign rsp_channel.valid       = rsp_valid_ff;
   assign rsp_channel.status      = out_ff.status;
   assign rsp_channel.result_id   = out_ff.result_id;
   assign rsp_channel.result_slot = out_ff.result_slot;
   assign rsp_channel.result_io   = out_ff.result_io;
   assign rsp_channel.switched    = out_ff.switched;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_THREADS))
      else $error("run queue count beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      (tail_ff - head_ff) == count_ff[SLOT_W-1:0])
      else $error("run queue pointers disagree with count");

   assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (CNT_W'(cur_slot_ff) < regcnt_ff))
      else $error("current thread outside registered slots");

   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_DECODE))
      else $error("accepted transaction not decoded");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_channel.valid && !rsp_channel.ready) |=> $stable(out_ff))
      else $error("stalled response changed");
`endif

endmodule
